// ===== rtl/core/binary_diff_isolated_pixel_filter_unit_defines.svh =====
// Assertion macros shared by the filter RTL.
`ifndef BINARY_DIFF_ISOLATED_PIXEL_FILTER_UNIT_DEFINES_SVH
`define BINARY_DIFF_ISOLATED_PIXEL_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define BDIP_ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BDIP_ASSERT(label, prop, msg) \
  `BDIP_ASSERT_CLK(label, clk, rst, prop, msg)
`else
`define BDIP_ASSERT_CLK(label, clock, reset, prop, msg)
`define BDIP_ASSERT(label, prop, msg)
`endif
`endif

// ===== rtl/core/bdip_pkg.sv =====
package bdip_pkg;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 11;
  localparam int COORD_W    = 10;
  localparam int PUSH_MAX   = 3;
  localparam int PUSH_N_W   = 2;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int FIFO_CNT_W = 4;

  localparam logic [1:0] REG_REF_THRESHOLD  = 2'd0;
  localparam logic [1:0] REG_TEST_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd3;

  localparam logic [PIX_W-1:0]  REF_THRESHOLD_RESET  = 8'd89;
  localparam logic [PIX_W-1:0]  TEST_THRESHOLD_RESET = 8'd50;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET    = 11'd720;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET   = 11'd720;

  typedef logic [2:0] column_t;

  localparam column_t CENTER_ONLY = 3'b010;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               stain;
    logic               last_of_run;
    logic               frame_done;
  } result_t;

  typedef struct packed {
    logic [PUSH_N_W-1:0]          n;
    result_t [PUSH_MAX-1:0]       items;
  } push_t;

endpackage

// ===== rtl/core/bdip_ram.sv =====
module bdip_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bdip_window_cell.sv =====
module bdip_window_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  bdip_pkg::column_t col_in,
  output bdip_pkg::column_t col_q,
  output logic              clear
);
  import bdip_pkg::*;

  column_t col;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
    end else if (shift) begin
      col <= col_in;
    end
  end

  assign col_q = col;
  assign clear = (col == '0);

endmodule

// ===== rtl/core/bdip_result_fifo.sv =====
module bdip_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  bdip_pkg::push_t                 push,
  input  logic                            pop,
  output bdip_pkg::result_t               head,
  output logic                            not_empty,
  output logic [bdip_pkg::FIFO_CNT_W-1:0] count
);
  import bdip_pkg::*;

  result_t                mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr;
  logic [FIFO_PTR_W-1:0]  rd_ptr;
  logic [FIFO_CNT_W-1:0]  count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count_q <= '0;
    end else begin
      wr_ptr  <= wr_ptr + FIFO_PTR_W'(push.n);
      rd_ptr  <= rd_ptr + FIFO_PTR_W'(pop);
      count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (k < int'(push.n)) begin
        mem[wr_ptr + FIFO_PTR_W'(k)] <= push.items[k];
      end
    end
  end

  assign head      = mem[rd_ptr];
  assign not_empty = (count_q != '0);
  assign count     = count_q;

endmodule

// ===== rtl/core/binary_diff_isolated_pixel_filter_unit.sv =====
// Streams raster-order reference/inspected pixel pairs, thresholds each, XORs
// them into a difference mask and removes isolated set pixels with a 3x3
// window; border rows and columns pass unchanged. An input pixel is taken
// every cycle while the 8-entry result queue has room; each result passes
// through the s1 stage register and the result queue before it can leave.
// The output port moves one result per cycle while out_stall is low, which
// sets the sustained rate: one pixel per cycle on every row but the last.
// On the last row of a frame most pixels give two results, so the queue
// fills and stalls the input. Mask history lives in one 2-bit line store of
// MAX_WIDTH entries with a registered read; it needs no clearing after reset.
`include "binary_diff_isolated_pixel_filter_unit_defines.svh"

module binary_diff_isolated_pixel_filter_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [bdip_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bdip_pkg::PIX_W-1:0]    ref_pixel,
  input  logic [bdip_pkg::PIX_W-1:0]    test_pixel,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bdip_pkg::COORD_W-1:0]  out_row,
  output logic [bdip_pkg::COORD_W-1:0]  out_col,
  output logic                          stain,
  output logic                          last_of_run,
  output logic                          frame_done
);
  import bdip_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);
  localparam logic [COL_W-1:0] W_LAST_MAX = COL_W'(MAX_WIDTH - 1);
  localparam logic [ROW_W-1:0] H_LAST_MAX = ROW_W'(MAX_HEIGHT - 1);

  logic [PIX_W-1:0]  ref_threshold;
  logic [PIX_W-1:0]  test_threshold;
  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_threshold  <= REF_THRESHOLD_RESET;
      test_threshold <= TEST_THRESHOLD_RESET;
      frame_width    <= FRAME_WIDTH_RESET;
      frame_height   <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REF_THRESHOLD:  ref_threshold  <= cfg_data[PIX_W-1:0];
        REG_TEST_THRESHOLD: test_threshold <= cfg_data[PIX_W-1:0];
        REG_FRAME_WIDTH:    frame_width    <= cfg_data;
        REG_FRAME_HEIGHT:   frame_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  always_comb begin
    if (frame_width < 11'd3) begin
      w_last = COL_W'(2);
    end else if ({2'b00, frame_width} > MAXW) begin
      w_last = W_LAST_MAX;
    end else begin
      w_last = COL_W'(frame_width - 11'd1);
    end
    if (frame_height < 11'd3) begin
      h_last = ROW_W'(2);
    end else if ({2'b00, frame_height} > MAXH) begin
      h_last = H_LAST_MAX;
    end else begin
      h_last = ROW_W'(frame_height - 11'd1);
    end
  end

  logic                  in_accept;
  logic [COL_W-1:0]      col_count;
  logic [ROW_W-1:0]      row_count;
  logic [COL_W-1:0]      c0;
  logic [ROW_W-1:0]      r0;
  logic                  d0;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   room_need;

  logic             s1_valid;
  logic [COL_W-1:0] s1_c;
  logic [ROW_W-1:0] s1_r;
  logic             s1_d;
  logic             s1_clast;
  logic             s1_rlast;

  assign room_need = {1'b0, fifo_count} + (s1_valid ? (FIFO_CNT_W + 1)'(PUSH_MAX) : '0)
                     + (FIFO_CNT_W + 1)'(PUSH_MAX);
  assign in_stall  = (room_need > (FIFO_CNT_W + 1)'(FIFO_DEPTH));
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    c0 = (col_count > w_last) ? w_last : col_count;
    r0 = (row_count > h_last) ? h_last : row_count;
    if (frame_start) begin
      c0 = '0;
      r0 = '0;
    end
    d0 = (ref_pixel > ref_threshold) ^ (test_pixel > test_threshold);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= in_accept;
      if (in_accept) begin
        if (c0 == w_last) begin
          col_count <= '0;
          row_count <= (r0 == h_last) ? '0 : r0 + ROW_W'(1);
        end else begin
          col_count <= c0 + COL_W'(1);
          row_count <= r0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_c     <= c0;
      s1_r     <= r0;
      s1_d     <= d0;
      s1_clast <= (c0 == w_last);
      s1_rlast <= (r0 == h_last);
    end
  end

  logic [1:0] line_rd;
  logic [1:0] line_eff;
  logic [1:0] fwd_data;
  logic       collide;

  bdip_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_c),
    .wdata ({line_eff[0], s1_d}),
    .raddr (c0),
    .rdata (line_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      collide <= 1'b0;
    end else begin
      collide <= in_accept && s1_valid && (s1_c == c0);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= {line_eff[0], s1_d};
  end

  assign line_eff = collide ? fwd_data : line_rd;

  column_t column;
  column_t cell_col [2];
  logic    cell_clear [2];

  assign column = {line_eff[1], line_eff[0], s1_d};

  for (genvar i = 0; i < 2; i++) begin : g_cell
    bdip_window_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .shift  (s1_valid),
      .col_in ((i == 0) ? column : cell_col[0]),
      .col_q  (cell_col[i]),
      .clear  (cell_clear[i])
    );
  end

  push_t            push;
  logic             has_a;
  logic             has_b;
  logic             has_c;
  logic             isolated;
  logic [COL_W-1:0] c_prev;
  logic [ROW_W-1:0] r_prev;

  assign c_prev   = s1_c - COL_W'(1);
  assign r_prev   = s1_r - ROW_W'(1);
  assign has_a    = s1_valid && (s1_r != '0) && (s1_c != '0);
  assign has_b    = s1_valid && (s1_r != '0) && s1_clast;
  assign has_c    = s1_valid && s1_rlast;
  assign isolated = (s1_r > ROW_W'(1)) && (s1_c > COL_W'(1)) && (column == '0)
                    && (cell_col[0] == CENTER_ONLY) && cell_clear[1];

  always_comb begin
    logic [PUSH_N_W-1:0] idx;
    result_t             res;
    push = '0;
    idx  = '0;
    res  = '0;
    if (has_a) begin
      res.row         = COORD_W'(r_prev);
      res.col         = COORD_W'(c_prev);
      res.stain       = cell_col[0][1] && !isolated;
      res.last_of_run = !has_b && !has_c;
      res.frame_done  = 1'b0;
      push.items[idx] = res;
      idx             = idx + PUSH_N_W'(1);
    end
    if (has_b) begin
      res.row         = COORD_W'(r_prev);
      res.col         = COORD_W'(s1_c);
      res.stain       = column[1];
      res.last_of_run = !has_c;
      res.frame_done  = 1'b0;
      push.items[idx] = res;
      idx             = idx + PUSH_N_W'(1);
    end
    if (has_c) begin
      res.row         = COORD_W'(s1_r);
      res.col         = COORD_W'(s1_c);
      res.stain       = s1_d;
      res.last_of_run = 1'b1;
      res.frame_done  = s1_clast;
      push.items[idx] = res;
      idx             = idx + PUSH_N_W'(1);
    end
    push.n = idx;
  end

  result_t head;
  logic    pop;

  assign pop = out_valid && !out_stall;

  bdip_result_fifo u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .count     (fifo_count)
  );

  assign out_row     = head.row;
  assign out_col     = head.col;
  assign stain       = head.stain;
  assign last_of_run = head.last_of_run;
  assign frame_done  = head.frame_done;

  `BDIP_ASSERT(a_done_is_last, out_valid && frame_done |-> last_of_run, "done but not last")
  `BDIP_ASSERT(a_row0_silent, s1_valid && (s1_r == '0) |-> (push.n == '0), "result from row 0")
  `BDIP_ASSERT(a_fwd_after_write, collide |-> $past(s1_valid), "bypass without a write")
  `BDIP_ASSERT(a_three_at_corner, (push.n == 2'd3) |-> s1_clast && s1_rlast, "three results")

endmodule
